// File: rtl/assert_macros.svh
// Assertion helpers used by the top-level RTL file, which checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside of reset.
`define QSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true outside of reset.
`define QSE_NEVER(lbl, cond, msg) \
  `QSE_ASSERT(lbl, !(cond), msg)

`endif

// File: rtl/qse_pkg.sv
package qse_pkg;

  localparam int CNT_W      = 13;
  localparam int HALF_W     = 14;
  localparam int PIX_W      = 12;
  localparam int WEIGHT_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int MAX_PIX    = 4;
  localparam int SLOT_W     = 2;

  localparam logic [CNT_W-1:0] MAX_WIDTH  = 13'd4096;
  localparam logic [CNT_W-1:0] MAX_HEIGHT = 13'd4096;

  localparam logic [CFG_DATA_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [CFG_DATA_W-1:0] RESET_HEIGHT = 13'd480;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic [WEIGHT_W-1:0] WEIGHT_CORNER = 3'd1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_CENTRE = 3'd4;

  typedef struct packed {
    logic [CNT_W-1:0] col;
    logic [CNT_W-1:0] row;
    logic             centre;
  } walk_t;

  // All results of one sample: shared position and weight, one pixel per slot.
  typedef struct packed {
    logic [HALF_W-1:0]               sx;
    logic [HALF_W-1:0]               sy;
    logic [WEIGHT_W-1:0]             weight;
    logic                            done;
    logic [MAX_PIX-1:0][PIX_W-1:0]   px;
    logic [MAX_PIX-1:0][PIX_W-1:0]   py;
    logic [SLOT_W-1:0]               last_slot;
  } burst_t;

  typedef struct packed {
    logic [HALF_W-1:0]   sample_x_half;
    logic [HALF_W-1:0]   sample_y_half;
    logic [WEIGHT_W-1:0] weight_eighths;
    logic [PIX_W-1:0]    pixel_x;
    logic [PIX_W-1:0]    pixel_y;
    logic                last_of_sample;
    logic                frame_done;
  } res_t;

  typedef struct packed {
    logic busy;
    logic take_ok;
  } emit_status_t;

endpackage

// File: rtl/qse_if.sv
interface qse_req_if;
  logic valid;
  logic ready;
  logic frame_restart;

  modport source (output valid, output frame_restart, input ready);
  modport sink   (input valid, input frame_restart, output ready);
endinterface

interface qse_res_if import qse_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [HALF_W-1:0]   sample_x_half;
  logic [HALF_W-1:0]   sample_y_half;
  logic [WEIGHT_W-1:0] weight_eighths;
  logic [PIX_W-1:0]    pixel_x;
  logic [PIX_W-1:0]    pixel_y;
  logic                last_of_sample;
  logic                frame_done;

  modport source (output valid, output sample_x_half, output sample_y_half,
                  output weight_eighths, output pixel_x, output pixel_y,
                  output last_of_sample, output frame_done, input ready);
  modport sink   (input valid, input sample_x_half, input sample_y_half,
                  input weight_eighths, input pixel_x, input pixel_y,
                  input last_of_sample, input frame_done, output ready);
endinterface

interface qse_cfg_if import qse_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/quincunx_sample_enumerator.sv
// A request word that is accepted is held in the emitter's burst register; its first result
// word enters the output register once that register is empty or its word is taken.
// Throughput: one result word per cycle while the output is not stalled; a request has
// one result for a centre and one to four for a corner, sent from the single output register.
// Reset: counters return to vertex zero in the corner phase, width 640 and height 480,
// and both channels come up empty.
`include "assert_macros.svh"

module quincunx_sample_enumerator import qse_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  qse_cfg_if.sink   cfg_i,
  qse_req_if.sink   req_i,
  qse_res_if.source res_o
);

  logic [CFG_DATA_W-1:0] image_width_q;
  logic [CFG_DATA_W-1:0] image_height_q;
  walk_t                 walk_q;
  walk_t                 walk_d;
  burst_t                burst;
  logic                  accept;
  res_t                  res;
  emit_status_t          status;
  logic                  res_centre;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= RESET_WIDTH;
      image_height_q <= RESET_HEIGHT;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_IMAGE_WIDTH:  image_width_q  <= cfg_i.data;
        CFG_IMAGE_HEIGHT: image_height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign req_i.ready = status.take_ok;
  assign accept      = req_i.valid && status.take_ok;

  qse_step u_step (
    .image_width_i  (image_width_q),
    .image_height_i (image_height_q),
    .restart_i      (req_i.frame_restart),
    .walk_i         (walk_q),
    .walk_o         (walk_d),
    .burst_o        (burst)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q <= '0;
    end else if (accept) begin
      walk_q <= walk_d;
    end
  end

  qse_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .burst_i     (burst),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_o.valid),
    .res_o       (res),
    .status_o    (status)
  );

  assign res_o.sample_x_half  = res.sample_x_half;
  assign res_o.sample_y_half  = res.sample_y_half;
  assign res_o.weight_eighths = res.weight_eighths;
  assign res_o.pixel_x        = res.pixel_x;
  assign res_o.pixel_y        = res.pixel_y;
  assign res_o.last_of_sample = res.last_of_sample;
  assign res_o.frame_done     = res.frame_done;

  assign res_centre = (res_o.weight_eighths == WEIGHT_CENTRE);

  `QSE_ASSERT(a_accept_busy, accept |=> status.busy, "accepted request left emitter idle")
  `QSE_NEVER(a_idle_ready, !status.busy && !req_i.ready, "idle emitter refused a request")
  `QSE_NEVER(a_centre_single, res_o.valid && res_centre && !res_o.last_of_sample, "split centre")
  `QSE_NEVER(a_done_centre, res_o.valid && res_o.frame_done && !res_centre, "corner frame end")

endmodule

// File: rtl/qse_step.sv
module qse_step import qse_pkg::*; (
  input  logic [CFG_DATA_W-1:0] image_width_i,
  input  logic [CFG_DATA_W-1:0] image_height_i,
  input  logic                  restart_i,
  input  walk_t                 walk_i,
  output walk_t                 walk_o,
  output burst_t                burst_o
);

  logic [CNT_W-1:0]                w;
  logic [CNT_W-1:0]                h;
  walk_t                           cur;
  logic [CNT_W-1:0]                x;
  logic [CNT_W-1:0]                y;
  logic [MAX_PIX-1:0]              cand_ok;
  logic [MAX_PIX-1:0][PIX_W-1:0]   cand_x;
  logic [MAX_PIX-1:0][PIX_W-1:0]   cand_y;
  logic [2:0]                      n;

  always_comb begin
    if (image_width_i == '0) begin
      w = 13'd1;
    end else if (image_width_i > MAX_WIDTH) begin
      w = MAX_WIDTH;
    end else begin
      w = image_width_i;
    end
    if (image_height_i == '0) begin
      h = 13'd1;
    end else if (image_height_i > MAX_HEIGHT) begin
      h = MAX_HEIGHT;
    end else begin
      h = image_height_i;
    end
  end

  // A position outside the current grid restarts the frame at vertex zero.
  always_comb begin
    cur = restart_i ? '0 : walk_i;
    if (!cur.centre) begin
      if (cur.col > w || cur.row > h) begin
        cur.col = '0;
        cur.row = '0;
      end
    end else if (cur.col >= w || cur.row >= h) begin
      cur = '0;
    end
    x = cur.col;
    y = cur.row;
  end

  // Pixels sharing the corner, tested upper left, upper right, lower left, lower right.
  always_comb begin
    cand_ok[0] = (x != '0) && (y != '0);
    cand_ok[1] = (y != '0) && (x < w);
    cand_ok[2] = (x != '0) && (y < h);
    cand_ok[3] = (x < w) && (y < h);
    cand_x[0]  = PIX_W'(x - 13'd1);
    cand_y[0]  = PIX_W'(y - 13'd1);
    cand_x[1]  = PIX_W'(x);
    cand_y[1]  = PIX_W'(y - 13'd1);
    cand_x[2]  = PIX_W'(x - 13'd1);
    cand_y[2]  = PIX_W'(y);
    cand_x[3]  = PIX_W'(x);
    cand_y[3]  = PIX_W'(y);
  end

  always_comb begin
    burst_o = '0;
    walk_o  = cur;
    n       = '0;
    if (!cur.centre) begin
      burst_o.sx     = {x, 1'b0};
      burst_o.sy     = {y, 1'b0};
      burst_o.weight = WEIGHT_CORNER;
      for (int k = 0; k < MAX_PIX; k++) begin
        if (cand_ok[k]) begin
          burst_o.px[n[SLOT_W-1:0]] = cand_x[k];
          burst_o.py[n[SLOT_W-1:0]] = cand_y[k];
          n = n + 3'd1;
        end
      end
      burst_o.last_slot = SLOT_W'(n - 3'd1);
      if (x == w) begin
        walk_o.col = '0;
        if (y == h) begin
          walk_o.row    = '0;
          walk_o.centre = 1'b1;
        end else begin
          walk_o.row = y + 13'd1;
        end
      end else begin
        walk_o.col = x + 13'd1;
      end
    end else begin
      burst_o.sx        = {x, 1'b1};
      burst_o.sy        = {y, 1'b1};
      burst_o.weight    = WEIGHT_CENTRE;
      burst_o.px[0]     = PIX_W'(x);
      burst_o.py[0]     = PIX_W'(y);
      burst_o.last_slot = '0;
      burst_o.done      = (x == w - 13'd1) && (y == h - 13'd1);
      if (x == w - 13'd1) begin
        walk_o.col = '0;
        if (y == h - 13'd1) begin
          walk_o.row    = '0;
          walk_o.centre = 1'b0;
        end else begin
          walk_o.row = y + 13'd1;
        end
      end else begin
        walk_o.col = x + 13'd1;
      end
    end
  end

endmodule

// File: rtl/qse_emit.sv
module qse_emit import qse_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  burst_t       burst_i,
  input  logic         res_ready_i,
  output logic         res_valid_o,
  output res_t         res_o,
  output emit_status_t status_o
);

  burst_t            burst_q;
  logic              busy_q;
  logic [SLOT_W-1:0] slot_q;
  logic              res_valid_q;
  res_t              res_q;
  logic              out_load;
  logic              send;
  logic              last_send;
  res_t              word;

  // The output register takes a new word when empty or when its word leaves.
  assign out_load  = !res_valid_q || res_ready_i;
  assign send      = busy_q && out_load;
  assign last_send = send && (slot_q == burst_q.last_slot);

  assign status_o.busy    = busy_q;
  assign status_o.take_ok = !busy_q || last_send;

  always_comb begin
    word.sample_x_half  = burst_q.sx;
    word.sample_y_half  = burst_q.sy;
    word.weight_eighths = burst_q.weight;
    word.pixel_x        = burst_q.px[slot_q];
    word.pixel_y        = burst_q.py[slot_q];
    word.last_of_sample = (slot_q == burst_q.last_slot);
    word.frame_done     = burst_q.done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      slot_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        busy_q <= 1'b1;
        slot_q <= '0;
      end else if (last_send) begin
        busy_q <= 1'b0;
      end else if (send) begin
        slot_q <= slot_q + SLOT_W'(1);
      end
      if (send) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q <= burst_i;
    end
    if (send) begin
      res_q <= word;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// File: dv/tb_quincunx_sample_enumerator.sv
`timescale 1ns / 1ps

module tb_quincunx_sample_enumerator;
  import qse_pkg::*;

  // Indexes that name no register; writes to them must leave the sizes alone.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;

  typedef enum logic {ROW_WRITE, ROW_REQUEST} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] value;
    bit                    restart;
    bit                    typed;
    res_t                  word;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  qse_cfg_if cfg_bus ();
  qse_req_if req_bus ();
  qse_res_if res_bus ();

  quincunx_sample_enumerator i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .req_i  (req_bus),
    .res_o  (res_bus)
  );

  // Mirror of the size registers and of the walk position.
  logic [CFG_DATA_W-1:0] width_reg   = RESET_WIDTH;
  logic [CFG_DATA_W-1:0] height_reg  = RESET_HEIGHT;
  int unsigned           walk_col    = 0;
  int unsigned           walk_row    = 0;
  bit                    walk_centre = 1'b0;

  res_t      sample_words[$];
  res_t      due_words[$];
  stim_row_t stim_rows[$];
  res_t      seen_word;
  res_t      due_word;

  int req_gap_pct   = 24;
  int res_stall_pct = 61;
  int hold_left     = 0;
  bit hold_req      = 1'b0;
  bit hold_taken    = 1'b0;
  int mismatches    = 0;
  int words_checked = 0;
  int frames_seen   = 0;
  int requests_sent = 0;
  int restarts_sent = 0;

  function automatic int unsigned usable_size(input logic [CFG_DATA_W-1:0] v,
                                              input logic [CNT_W-1:0] cap);
    if (v == '0) return 1;
    if (v > cap) return 32'(cap);
    return 32'(v);
  endfunction

  // Works out every result word of the next sample and moves the walk on.
  function automatic void enumerate_next_sample(input bit restart);
    int unsigned w, h, x, y, cx, cy, n;
    int unsigned px [4];
    int unsigned py [4];
    res_t word;
    w = usable_size(width_reg, MAX_WIDTH);
    h = usable_size(height_reg, MAX_HEIGHT);
    sample_words.delete();
    if (restart) begin
      walk_col    = 0;
      walk_row    = 0;
      walk_centre = 1'b0;
    end
    // A walk left outside a shrunken grid starts over at vertex zero.
    if (!walk_centre) begin
      if (walk_col > w || walk_row > h) begin
        walk_col = 0;
        walk_row = 0;
      end
    end else if (walk_col >= w || walk_row >= h) begin
      walk_col    = 0;
      walk_row    = 0;
      walk_centre = 1'b0;
    end
    x = walk_col;
    y = walk_row;
    n = 0;
    if (!walk_centre) begin
      for (int dy = 0; dy < 2; dy++) begin
        for (int dx = 0; dx < 2; dx++) begin
          if ((dx != 0 || x != 0) && (dy != 0 || y != 0)) begin
            cx = x - 1 + dx;
            cy = y - 1 + dy;
            if (cx < w && cy < h) begin
              px[n] = cx;
              py[n] = cy;
              n++;
            end
          end
        end
      end
      for (int k = 0; k < n; k++) begin
        word.sample_x_half  = HALF_W'(2 * x);
        word.sample_y_half  = HALF_W'(2 * y);
        word.weight_eighths = WEIGHT_CORNER;
        word.pixel_x        = PIX_W'(px[k]);
        word.pixel_y        = PIX_W'(py[k]);
        word.last_of_sample = (k == n - 1);
        word.frame_done     = 1'b0;
        sample_words.push_back(word);
      end
      walk_col = x + 1;
      if (walk_col > w) begin
        walk_col = 0;
        walk_row = y + 1;
        if (walk_row > h) begin
          walk_row    = 0;
          walk_centre = 1'b1;
        end
      end
    end else begin
      word.sample_x_half  = HALF_W'(2 * x + 1);
      word.sample_y_half  = HALF_W'(2 * y + 1);
      word.weight_eighths = WEIGHT_CENTRE;
      word.pixel_x        = PIX_W'(x);
      word.pixel_y        = PIX_W'(y);
      word.last_of_sample = 1'b1;
      word.frame_done     = (x == w - 1 && y == h - 1);
      sample_words.push_back(word);
      walk_col = x + 1;
      if (walk_col >= w) begin
        walk_col = 0;
        walk_row = y + 1;
        if (walk_row >= h) begin
          walk_row    = 0;
          walk_centre = 1'b0;
        end
      end
    end
  endfunction

  function automatic res_t single_word(input int unsigned sx, input int unsigned sy,
                                       input logic [WEIGHT_W-1:0] weight,
                                       input int unsigned px, input int unsigned py,
                                       input bit frame_end);
    res_t word;
    word.sample_x_half  = HALF_W'(sx);
    word.sample_y_half  = HALF_W'(sy);
    word.weight_eighths = weight;
    word.pixel_x        = PIX_W'(px);
    word.pixel_y        = PIX_W'(py);
    word.last_of_sample = 1'b1;
    word.frame_done     = frame_end;
    return word;
  endfunction

  function automatic void row_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] value);
    stim_row_t r;
    r.kind    = ROW_WRITE;
    r.idx     = idx;
    r.value   = value;
    r.restart = 1'b0;
    r.typed   = 1'b0;
    r.word    = '0;
    stim_rows.push_back(r);
  endfunction

  function automatic void row_request(input bit restart, input bit typed, input res_t word);
    stim_row_t r;
    r.kind    = ROW_REQUEST;
    r.idx     = '0;
    r.value   = '0;
    r.restart = restart;
    r.typed   = typed;
    r.word    = word;
    stim_rows.push_back(r);
  endfunction

  function automatic int unsigned pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(1, 4);
    if (r < 80) return 0;
    if (r < 85) return 4096;
    if (r < 90) return 8191;
    return $urandom_range(0, 8191);
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic offer_request(input bit restart, input bit typed, input res_t typed_word);
    while ($urandom_range(99) < req_gap_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid         <= 1'b1;
    req_bus.frame_restart <= restart;
    do @(posedge clk_i); while (!req_bus.ready);
    enumerate_next_sample(restart);
    if (typed) begin
      due_words.push_back(typed_word);
    end else begin
      foreach (sample_words[k]) due_words.push_back(sample_words[k]);
    end
    requests_sent++;
    restarts_sent += restart;
    @(negedge clk_i);
  endtask

  task automatic run_items(input int count, input int restart_pct);
    for (int i = 0; i < count; i++) begin
      offer_request($urandom_range(99) < restart_pct, 1'b0, '0);
    end
  endtask

  task automatic drain_results();
    req_bus.valid <= 1'b0;
    while (due_words.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    if (idx == CFG_IMAGE_WIDTH) begin
      width_reg = value;
    end else if (idx == CFG_IMAGE_HEIGHT) begin
      height_reg = value;
    end
    @(negedge clk_i);
  endtask

  task automatic resize(input int unsigned w, input int unsigned h);
    drain_results();
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic void match_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // The long output stall is counted here once the stimulus asks for it.
  always @(negedge clk_i) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      res_bus.ready <= 1'b0;
      hold_left--;
    end else begin
      res_bus.ready <= ($urandom_range(99) >= res_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      seen_word.sample_x_half  = res_bus.sample_x_half;
      seen_word.sample_y_half  = res_bus.sample_y_half;
      seen_word.weight_eighths = res_bus.weight_eighths;
      seen_word.pixel_x        = res_bus.pixel_x;
      seen_word.pixel_y        = res_bus.pixel_y;
      seen_word.last_of_sample = res_bus.last_of_sample;
      seen_word.frame_done     = res_bus.frame_done;
      if (due_words.size() == 0) begin
        mismatches++;
        $display("%0t: result word with nothing expected, sample (%0d,%0d) pixel (%0d,%0d)",
                 $time, seen_word.sample_x_half, seen_word.sample_y_half,
                 seen_word.pixel_x, seen_word.pixel_y);
      end else begin
        due_word = due_words.pop_front();
        match_field("sample_x_half", due_word.sample_x_half, seen_word.sample_x_half);
        match_field("sample_y_half", due_word.sample_y_half, seen_word.sample_y_half);
        match_field("weight_eighths", due_word.weight_eighths, seen_word.weight_eighths);
        match_field("pixel_x", due_word.pixel_x, seen_word.pixel_x);
        match_field("pixel_y", due_word.pixel_y, seen_word.pixel_y);
        match_field("last_of_sample", due_word.last_of_sample, seen_word.last_of_sample);
        match_field("frame_done", due_word.frame_done, seen_word.frame_done);
        words_checked++;
        if (seen_word.frame_done) frames_seen++;
      end
    end
  end

  initial begin
    int idle_run;
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        idle_run = 0;
      end else begin
        idle_run++;
      end
    end
    $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    bit cfg_open;
    int n;
    req_bus.valid         = 1'b0;
    req_bus.frame_restart = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.index         = '0;
    cfg_bus.data          = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: reset sizes, a 1x1 frame end to end, clamped and extreme
    // sizes, a shrink that strands the walk, and writes to unused indexes.
    row_request(1'b0, 1'b1, single_word(0, 0, WEIGHT_CORNER, 0, 0, 1'b0));
    row_request(1'b0, 1'b0, '0);
    row_request(1'b1, 1'b1, single_word(0, 0, WEIGHT_CORNER, 0, 0, 1'b0));
    row_write(CFG_IMAGE_WIDTH, 1);
    row_write(CFG_IMAGE_HEIGHT, 1);
    row_request(1'b1, 1'b1, single_word(0, 0, WEIGHT_CORNER, 0, 0, 1'b0));
    row_request(1'b0, 1'b1, single_word(2, 0, WEIGHT_CORNER, 0, 0, 1'b0));
    row_request(1'b0, 1'b1, single_word(0, 2, WEIGHT_CORNER, 0, 0, 1'b0));
    row_request(1'b0, 1'b1, single_word(2, 2, WEIGHT_CORNER, 0, 0, 1'b0));
    row_request(1'b0, 1'b1, single_word(1, 1, WEIGHT_CENTRE, 0, 0, 1'b1));
    row_request(1'b0, 1'b1, single_word(0, 0, WEIGHT_CORNER, 0, 0, 1'b0));
    row_write(CFG_IMAGE_WIDTH, 0);
    row_write(CFG_IMAGE_HEIGHT, 8191);
    for (int i = 0; i < 3; i++) row_request(1'b0, 1'b0, '0);
    row_write(CFG_IMAGE_WIDTH, 4096);
    row_write(CFG_IMAGE_HEIGHT, 4096);
    row_request(1'b1, 1'b1, single_word(0, 0, WEIGHT_CORNER, 0, 0, 1'b0));
    for (int i = 0; i < 3; i++) row_request(1'b0, 1'b0, '0);
    row_write(CFG_IMAGE_WIDTH, 2);
    row_write(CFG_IMAGE_HEIGHT, 3);
    row_request(1'b0, 1'b1, single_word(0, 0, WEIGHT_CORNER, 0, 0, 1'b0));
    row_write(CFG_SPARE_LO, CFG_DATA_W'($urandom_range(0, 8191)));
    row_write(CFG_SPARE_HI, CFG_DATA_W'($urandom_range(0, 8191)));
    row_request(1'b1, 1'b0, '0);
    row_request(1'b0, 1'b0, '0);

    cfg_open = 1'b0;
    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_WRITE) begin
        if (!cfg_open) drain_results();
        write_reg(stim_rows[i].idx, stim_rows[i].value);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_bus.valid <= 1'b0;
        cfg_open = 1'b0;
        offer_request(stim_rows[i].restart, stim_rows[i].typed, stim_rows[i].word);
      end
    end

    // Stop a 3x3 frame two centres in, then narrow it so the walk is stranded.
    resize(3, 3);
    offer_request(1'b1, 1'b0, '0);
    run_items(17, 0);
    resize(1, 3);
    run_items(3, 0);

    for (int lap = 0; lap < 3; lap++) begin
      req_gap_pct   = (lap == 0) ? 24 : (lap == 1) ? 61 : 0;
      res_stall_pct = (lap == 0) ? 61 : (lap == 1) ? 24 : 0;
      for (int part = 0; part < 4; part++) begin
        resize(pick_size(), pick_size());
        n = $urandom_range(18, 26);
        if (lap == 2 && part == 0) hold_req = 1'b1;
        if (lap == 1 && part == 1) begin
          run_items(n / 2, 4);
          drain_results();
          run_items(n - n / 2, 4);
        end else begin
          run_items(n, 4);
        end
      end
    end

    drain_results();
    repeat (8) @(negedge clk_i);
    $display("Sent %0d requests (%0d restarts), checked %0d result words, %0d frames ended.",
             requests_sent, restarts_sent, words_checked, frames_seen);
    $display("Covered clamped and extreme sizes, stranded walks and a long output stall.");
    if (mismatches == 0 && due_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/qse_pkg.sv
rtl/qse_if.sv
rtl/qse_step.sv
rtl/qse_emit.sv
rtl/quincunx_sample_enumerator.sv
dv/tb_quincunx_sample_enumerator.sv
